/* rtl/core/stok_pkg.sv */
// ----------------------------------------------------------------------------
// Source tokenizer package
// Token kinds, character constants, keyword spelling and the token record
// shared by the scanner, the result queue and the top level.
// ----------------------------------------------------------------------------
package stok_pkg;

  // Fixed widths of the result fields.
  typedef logic [15:0] line_t;
  typedef logic [23:0] offset_t;
  typedef logic [7:0]  length_t;
  typedef logic [31:0] value_t;
  typedef logic [7:0]  char_t;

  // Token kinds as they appear on the result channel.
  typedef enum logic [3:0] {
    KIND_EOF     = 4'd0,
    KIND_ILLEGAL = 4'd1,
    KIND_IDENT   = 4'd2,
    KIND_NUMBER  = 4'd3,
    KIND_WRITE   = 4'd4,
    KIND_INT     = 4'd5,
    KIND_LBRACE  = 4'd6,
    KIND_RBRACE  = 4'd7,
    KIND_LPAREN  = 4'd8,
    KIND_RPAREN  = 4'd9,
    KIND_PLUS    = 4'd10,
    KIND_MINUS   = 4'd11,
    KIND_STAR    = 4'd12,
    KIND_EQUALS  = 4'd13,
    KIND_SLASH   = 4'd14,
    KIND_NEWLINE = 4'd15
  } kind_t;

  // Characters of interest.
  localparam char_t CH_END    = 8'h00;
  localparam char_t CH_TAB    = 8'h09;
  localparam char_t CH_LF     = 8'h0A;
  localparam char_t CH_CR     = 8'h0D;
  localparam char_t CH_SPACE  = 8'h20;
  localparam char_t CH_LPAREN = 8'h28;
  localparam char_t CH_RPAREN = 8'h29;
  localparam char_t CH_STAR   = 8'h2A;
  localparam char_t CH_PLUS   = 8'h2B;
  localparam char_t CH_MINUS  = 8'h2D;
  localparam char_t CH_SLASH  = 8'h2F;
  localparam char_t CH_ZERO   = 8'h30;
  localparam char_t CH_NINE   = 8'h39;
  localparam char_t CH_EQUALS = 8'h3D;
  localparam char_t CH_UPPER_A = 8'h41;
  localparam char_t CH_UPPER_Z = 8'h5A;
  localparam char_t CH_UNDER  = 8'h5F;
  localparam char_t CH_LOWER_A = 8'h61;
  localparam char_t CH_LOWER_I = 8'h69;
  localparam char_t CH_LOWER_W = 8'h77;
  localparam char_t CH_LOWER_Z = 8'h7A;
  localparam char_t CH_LBRACE = 8'h7B;
  localparam char_t CH_RBRACE = 8'h7D;

  // Keyword lengths and the bit of each in the keyword match mask.
  localparam length_t WRITE_LEN = 8'd5;
  localparam length_t INT_LEN   = 8'd3;
  localparam int      KW_WRITE  = 0;
  localparam int      KW_INT    = 1;

  // Depth of the result queue; the scanner needs room for two tokens.
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

  // Spelling of "write", one character per position.
  function automatic char_t write_char(input logic [2:0] idx);
    char_t ch;
    case (idx)
      3'd0:    ch = 8'h77;
      3'd1:    ch = 8'h72;
      3'd2:    ch = 8'h69;
      3'd3:    ch = 8'h74;
      3'd4:    ch = 8'h65;
      default: ch = CH_END;
    endcase
    return ch;
  endfunction

  // Spelling of "int", one character per position.
  function automatic char_t int_char(input logic [1:0] idx);
    char_t ch;
    case (idx)
      2'd0:    ch = 8'h69;
      2'd1:    ch = 8'h6E;
      2'd2:    ch = 8'h74;
      default: ch = CH_END;
    endcase
    return ch;
  endfunction

  // One result item.
  typedef struct packed {
    kind_t   token_kind;
    line_t   token_line;
    line_t   token_column;
    offset_t token_offset;
    length_t token_length;
    value_t  number_value;
    logic    last_of_run;
  } token_t;

  // Tokens handed from the scanner to the result queue in one cycle.
  typedef struct packed {
    logic [1:0] count;
    token_t     tok0;
    token_t     tok1;
  } push_t;

endpackage

/* rtl/core/stok_if.sv */
// ----------------------------------------------------------------------------
// Source tokenizer channels
// Valid/ready channels for source bytes and for result tokens.
// ----------------------------------------------------------------------------

// Source byte channel.
interface stok_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;

  modport source (output valid, output text_byte, input ready);
  modport sink (input valid, input text_byte, output ready);
endinterface

// Result token channel.
interface stok_token_if;
  logic        valid;
  logic        ready;
  logic [3:0]  token_kind;
  logic [15:0] token_line;
  logic [15:0] token_column;
  logic [23:0] token_offset;
  logic [7:0]  token_length;
  logic [31:0] number_value;
  logic        last_of_run;

  modport source (
    output valid, output token_kind, output token_line, output token_column,
    output token_offset, output token_length, output number_value,
    output last_of_run, input ready
  );
  modport sink (
    input valid, input token_kind, input token_line, input token_column,
    input token_offset, input token_length, input number_value,
    input last_of_run, output ready
  );
endinterface

/* rtl/core/stok_scan.sv */
// ----------------------------------------------------------------------------
// Source tokenizer scanner
// Registers each source byte, classifies it against the scan mode and
// produces zero, one or two tokens per byte for the result queue.
// ----------------------------------------------------------------------------
module stok_scan #(
  parameter int LINE_BITS   = 16,
  parameter int OFFSET_BITS = 24,
  parameter int VALUE_BITS  = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  stok_byte_if.sink         in_chan,
  input  logic              room,
  output stok_pkg::push_t   push
);

  localparam int WIDE_BITS = VALUE_BITS + 4;
  localparam logic [LINE_BITS-1:0]   LINE_ONE = 1;
  localparam logic [OFFSET_BITS-1:0] OFF_ONE  = 1;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_SLASH,
    MODE_COMMENT,
    MODE_NUMBER,
    MODE_IDENT
  } mode_t;

  // Input register.
  logic                    byte_vld_r;
  stok_pkg::char_t         byte_r;
  logic                    fire;

  // Scan state.
  mode_t                   mode_r, mode_nxt;
  logic [LINE_BITS-1:0]    line_r, line_nxt;
  logic [LINE_BITS-1:0]    col_r, col_nxt;
  logic [OFFSET_BITS-1:0]  off_r, off_nxt;
  logic [LINE_BITS-1:0]    st_line_r, st_line_nxt;
  logic [LINE_BITS-1:0]    st_col_r, st_col_nxt;
  logic [OFFSET_BITS-1:0]  st_off_r, st_off_nxt;
  stok_pkg::length_t       len_r, len_nxt;
  logic [VALUE_BITS-1:0]   val_r, val_nxt;
  logic [1:0]              kw_r, kw_nxt;

  // Per-byte working signals.
  logic [LINE_BITS-1:0]    col_inc;
  logic                    is_digit, is_letter, is_under, absorb;
  logic [WIDE_BITS-1:0]    val_wide;
  logic [VALUE_BITS-1:0]   val_add;
  stok_pkg::length_t       len_inc;
  logic                    pend_vld, new_vld;
  stok_pkg::token_t        pend_tok, new_tok;

  // A byte moves on when the queue can take two tokens.
  assign fire           = byte_vld_r && room;
  assign in_chan.ready  = !byte_vld_r || fire;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_vld_r <= 1'b0;
    end else if (in_chan.ready) begin
      byte_vld_r <= in_chan.valid;
    end
    if (in_chan.ready && in_chan.valid) begin
      byte_r <= in_chan.text_byte;
    end
  end

  // Character classes and the running arithmetic.
  always_comb begin
    is_digit  = (byte_r >= stok_pkg::CH_ZERO) && (byte_r <= stok_pkg::CH_NINE);
    is_letter = ((byte_r >= stok_pkg::CH_LOWER_A) && (byte_r <= stok_pkg::CH_LOWER_Z)) ||
                ((byte_r >= stok_pkg::CH_UPPER_A) && (byte_r <= stok_pkg::CH_UPPER_Z));
    is_under  = (byte_r == stok_pkg::CH_UNDER);
    col_inc   = (&col_r) ? col_r : col_r + LINE_ONE;
    len_inc   = (&len_r) ? len_r : len_r + 8'd1;
    // Value times ten plus the digit; any carry into the top bits saturates.
    val_wide  = ({4'b0000, val_r} << 3) + ({4'b0000, val_r} << 1) +
                WIDE_BITS'(byte_r[3:0]);
    val_add   = (|val_wide[WIDE_BITS-1:VALUE_BITS]) ? '1 : val_wide[VALUE_BITS-1:0];
  end

  // Scan decision and next state.
  always_comb begin
    mode_nxt    = mode_r;
    line_nxt    = line_r;
    col_nxt     = col_r;
    off_nxt     = off_r;
    st_line_nxt = st_line_r;
    st_col_nxt  = st_col_r;
    st_off_nxt  = st_off_r;
    len_nxt     = len_r;
    val_nxt     = val_r;
    kw_nxt      = kw_r;
    pend_vld    = 1'b0;
    new_vld     = 1'b0;

    // Pending token as it would be flushed by this byte.
    pend_tok.token_kind   = stok_pkg::KIND_NUMBER;
    pend_tok.token_line   = stok_pkg::line_t'(st_line_r);
    pend_tok.token_column = stok_pkg::line_t'(st_col_r);
    pend_tok.token_offset = stok_pkg::offset_t'(st_off_r);
    pend_tok.token_length = len_r;
    pend_tok.number_value = '0;
    pend_tok.last_of_run  = 1'b0;

    // Token that starts at this byte.
    new_tok.token_kind    = stok_pkg::KIND_ILLEGAL;
    new_tok.token_line    = stok_pkg::line_t'(line_r);
    new_tok.token_column  = stok_pkg::line_t'(col_inc);
    new_tok.token_offset  = stok_pkg::offset_t'(off_r);
    new_tok.token_length  = 8'd1;
    new_tok.number_value  = '0;
    new_tok.last_of_run   = 1'b1;

    absorb = ((mode_r == MODE_NUMBER) && is_digit) ||
             ((mode_r == MODE_IDENT) && (is_letter || is_digit || is_under)) ||
             ((mode_r == MODE_SLASH) && (byte_r == stok_pkg::CH_SLASH)) ||
             ((mode_r == MODE_COMMENT) && (byte_r != stok_pkg::CH_LF) &&
              (byte_r != stok_pkg::CH_END));

    if (absorb) begin
      // The byte extends the current run or comment.
      unique case (mode_r)
        MODE_NUMBER: begin
          val_nxt = val_add;
          len_nxt = len_inc;
        end
        MODE_IDENT: begin
          if (!((len_r < stok_pkg::WRITE_LEN) &&
                (byte_r == stok_pkg::write_char(len_r[2:0])))) begin
            kw_nxt[stok_pkg::KW_WRITE] = 1'b0;
          end
          if (!((len_r < stok_pkg::INT_LEN) &&
                (byte_r == stok_pkg::int_char(len_r[1:0])))) begin
            kw_nxt[stok_pkg::KW_INT] = 1'b0;
          end
          len_nxt = len_inc;
        end
        MODE_SLASH: begin
          mode_nxt = MODE_COMMENT;
        end
        default: begin
        end
      endcase
    end else begin
      // Flush whatever token is pending.
      unique case (mode_r)
        MODE_NUMBER: begin
          pend_vld              = 1'b1;
          pend_tok.number_value = stok_pkg::value_t'(val_r);
        end
        MODE_IDENT: begin
          pend_vld = 1'b1;
          if (kw_r[stok_pkg::KW_WRITE] && (len_r == stok_pkg::WRITE_LEN)) begin
            pend_tok.token_kind = stok_pkg::KIND_WRITE;
          end else if (kw_r[stok_pkg::KW_INT] && (len_r == stok_pkg::INT_LEN)) begin
            pend_tok.token_kind = stok_pkg::KIND_INT;
          end else begin
            pend_tok.token_kind = stok_pkg::KIND_IDENT;
          end
        end
        MODE_SLASH: begin
          pend_vld              = 1'b1;
          pend_tok.token_kind   = stok_pkg::KIND_SLASH;
          pend_tok.token_length = 8'd1;
        end
        default: begin
        end
      endcase
      mode_nxt = MODE_IDLE;

      // Scan the byte afresh.
      unique case (byte_r) inside
        stok_pkg::CH_END: begin
          new_vld              = 1'b1;
          new_tok.token_kind   = stok_pkg::KIND_EOF;
        end
        stok_pkg::CH_SPACE, stok_pkg::CH_TAB, stok_pkg::CH_CR: begin
        end
        stok_pkg::CH_LBRACE: begin
          new_vld            = 1'b1;
          new_tok.token_kind = stok_pkg::KIND_LBRACE;
        end
        stok_pkg::CH_RBRACE: begin
          new_vld            = 1'b1;
          new_tok.token_kind = stok_pkg::KIND_RBRACE;
        end
        stok_pkg::CH_LPAREN: begin
          new_vld            = 1'b1;
          new_tok.token_kind = stok_pkg::KIND_LPAREN;
        end
        stok_pkg::CH_RPAREN: begin
          new_vld            = 1'b1;
          new_tok.token_kind = stok_pkg::KIND_RPAREN;
        end
        stok_pkg::CH_PLUS: begin
          new_vld            = 1'b1;
          new_tok.token_kind = stok_pkg::KIND_PLUS;
        end
        stok_pkg::CH_MINUS: begin
          new_vld            = 1'b1;
          new_tok.token_kind = stok_pkg::KIND_MINUS;
        end
        stok_pkg::CH_STAR: begin
          new_vld            = 1'b1;
          new_tok.token_kind = stok_pkg::KIND_STAR;
        end
        stok_pkg::CH_EQUALS: begin
          new_vld            = 1'b1;
          new_tok.token_kind = stok_pkg::KIND_EQUALS;
        end
        stok_pkg::CH_LF: begin
          new_vld            = 1'b1;
          new_tok.token_kind = stok_pkg::KIND_NEWLINE;
        end
        stok_pkg::CH_SLASH: begin
          // Hold the slash for one byte of lookahead.
          mode_nxt    = MODE_SLASH;
          st_line_nxt = line_r;
          st_col_nxt  = col_inc;
          st_off_nxt  = off_r;
          len_nxt     = '0;
          val_nxt     = '0;
          kw_nxt      = 2'b11;
        end
        default: begin
          if (is_digit) begin
            mode_nxt    = MODE_NUMBER;
            st_line_nxt = line_r;
            st_col_nxt  = col_inc;
            st_off_nxt  = off_r;
            len_nxt     = 8'd1;
            val_nxt     = VALUE_BITS'(byte_r[3:0]);
            kw_nxt      = 2'b11;
          end else if (is_letter) begin
            mode_nxt    = MODE_IDENT;
            st_line_nxt = line_r;
            st_col_nxt  = col_inc;
            st_off_nxt  = off_r;
            len_nxt     = 8'd1;
            val_nxt     = '0;
            kw_nxt[stok_pkg::KW_WRITE] = (byte_r == stok_pkg::CH_LOWER_W);
            kw_nxt[stok_pkg::KW_INT]   = (byte_r == stok_pkg::CH_LOWER_I);
          end else begin
            new_vld = 1'b1;
          end
        end
      endcase
    end

    // Advance the position, or return to the reset state at end of text.
    if (!absorb && (byte_r == stok_pkg::CH_END)) begin
      mode_nxt    = MODE_IDLE;
      line_nxt    = LINE_ONE;
      col_nxt     = '0;
      off_nxt     = '0;
      st_line_nxt = '0;
      st_col_nxt  = '0;
      st_off_nxt  = '0;
      len_nxt     = '0;
      val_nxt     = '0;
      kw_nxt      = 2'b11;
    end else begin
      if (byte_r == stok_pkg::CH_LF) begin
        line_nxt = (&line_r) ? line_r : line_r + LINE_ONE;
        col_nxt  = '0;
      end else begin
        col_nxt = col_inc;
      end
      off_nxt = (&off_r) ? off_r : off_r + OFF_ONE;
    end

    // Order the tokens; the last one of the byte carries the run marker.
    push.tok0 = pend_vld ? pend_tok : new_tok;
    push.tok1 = new_tok;
    push.tok0.last_of_run = !(pend_vld && new_vld);
    if (!fire) begin
      push.count = 2'd0;
    end else begin
      push.count = 2'(pend_vld) + 2'(new_vld);
    end
  end

  // Scan state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_IDLE;
      line_r    <= LINE_ONE;
      col_r     <= '0;
      off_r     <= '0;
      st_line_r <= '0;
      st_col_r  <= '0;
      st_off_r  <= '0;
      len_r     <= '0;
      val_r     <= '0;
      kw_r      <= 2'b11;
    end else if (fire) begin
      mode_r    <= mode_nxt;
      line_r    <= line_nxt;
      col_r     <= col_nxt;
      off_r     <= off_nxt;
      st_line_r <= st_line_nxt;
      st_col_r  <= st_col_nxt;
      st_off_r  <= st_off_nxt;
      len_r     <= len_nxt;
      val_r     <= val_nxt;
      kw_r      <= kw_nxt;
    end
  end

endmodule

/* rtl/core/stok_queue.sv */
// ----------------------------------------------------------------------------
// Source tokenizer result queue
// Small register queue that takes up to two tokens a cycle from the scanner
// and presents one token a cycle on the result channel while the sink is ready.
// ----------------------------------------------------------------------------
module stok_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  stok_pkg::push_t   push,
  output logic              room,
  stok_token_if.source      out_chan
);

  localparam int PW = stok_pkg::QUEUE_PTR_W;
  localparam int CW = stok_pkg::QUEUE_PTR_W + 1;
  localparam logic [CW-1:0] ROOM_LIMIT = CW'(stok_pkg::QUEUE_DEPTH - 2);

  stok_pkg::token_t  mem [stok_pkg::QUEUE_DEPTH];
  logic [PW-1:0]     wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]     count_r;
  logic              pop;
  stok_pkg::token_t  head;

  assign room           = (count_r <= ROOM_LIMIT);
  assign pop            = out_chan.valid && out_chan.ready;
  assign head           = mem[rd_ptr_r];

  // Present the oldest token.
  assign out_chan.valid        = (count_r != '0);
  assign out_chan.token_kind   = head.token_kind;
  assign out_chan.token_line   = head.token_line;
  assign out_chan.token_column = head.token_column;
  assign out_chan.token_offset = head.token_offset;
  assign out_chan.token_length = head.token_length;
  assign out_chan.number_value = head.number_value;
  assign out_chan.last_of_run  = head.last_of_run;

  // Token storage.
  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem[wr_ptr_r] <= push.tok0;
    end
    if (push.count == 2'd2) begin
      mem[wr_ptr_r + PW'(1)] <= push.tok1;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + PW'(push.count);
      rd_ptr_r <= rd_ptr_r + PW'(pop);
      count_r  <= count_r + CW'(push.count) - CW'(pop);
    end
  end

endmodule

/* rtl/core/source_tokenizer_top.sv */
// A byte is held in the input register while it is scanned; its tokens are then written into the result queue.
// Throughput: one source byte per cycle while the result queue has room for two tokens; a byte
// that ends a run and also forms a token of its own gives two tokens.
// The queue drains one token per cycle while out_chan is ready; a byte waits while it holds more than two.
// Reset: rst_n low at a clock edge clears the scan state and empties the queue.
// ----------------------------------------------------------------------------
// Source tokenizer top level
// Streaming lexical analyser: source bytes in, tokens with position, length
// and decimal value out.
// ----------------------------------------------------------------------------
module source_tokenizer_top #(
  parameter int LINE_BITS   = 16,
  parameter int OFFSET_BITS = 24,
  parameter int VALUE_BITS  = 32
) (
  input  logic           clk,
  input  logic           rst_n,
  stok_byte_if.sink      in_chan,
  stok_token_if.source   out_chan
);

  stok_pkg::push_t push;
  logic            room;

  // Byte register and scanner.
  stok_scan #(
    .LINE_BITS   (LINE_BITS),
    .OFFSET_BITS (OFFSET_BITS),
    .VALUE_BITS  (VALUE_BITS)
  ) u_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .room    (room),
    .push    (push)
  );

  // Result queue.
  stok_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .room     (room),
    .out_chan (out_chan)
  );

  // A pair of tokens marks only the second as the last of its byte.
  assert property (@(posedge clk) disable iff (!rst_n)
    (push.count == 2'd2) |-> (!push.tok0.last_of_run && push.tok1.last_of_run))
    else $error("token pair has wrong run marker");

  // End of text is always the last token of its byte.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && (out_chan.token_kind == stok_pkg::KIND_EOF)) |->
    out_chan.last_of_run)
    else $error("EOF token not marked last");

  // Only number tokens carry a value.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && (out_chan.token_kind != stok_pkg::KIND_NUMBER)) |->
    (out_chan.number_value == '0))
    else $error("non-number token carries a value");

  // Every token has a nonzero length.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid |-> (out_chan.token_length != '0))
    else $error("token with zero length");

  // The scanner never pushes while the queue lacks room for a pair.
  assert property (@(posedge clk) disable iff (!rst_n)
    !room |-> (push.count == 2'd0))
    else $error("push into full result queue");

endmodule
